>>> hw/rtl/biquad_cascade_highpass_top_defines.svh
// ----------------------------------------------------------------------------
// Biquad cascade assertion macros
// Shared concurrent assertion forms for the biquad cascade RTL.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_HIGHPASS_TOP_DEFINES_SVH
`define BIQUAD_CASCADE_HIGHPASS_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BQC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bqc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BQC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqc: next-cycle check failed");

`endif

>>> hw/rtl/bqc_pkg.sv
// ----------------------------------------------------------------------------
// Biquad cascade package
// Payload types, control word format, microcode program and rounding helpers.
// ----------------------------------------------------------------------------
package bqc_pkg;

   // Field widths and fixed-point constants.
   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 32;
   localparam int DLY_W       = 32;
   localparam int ACC_W       = 64;
   localparam int CIDX_W      = 5;
   localparam int ACT_W       = 3;
   localparam int ACC_FRAC_SH = 26;
   localparam int CSR_INDEX_W = 2;
   localparam int COEF_PER_STAGE = 5;
   localparam int DLY_PER_STAGE  = 2;

   // Commands carried by an input transfer.
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   // Configuration register indexes and reset values.
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_GAIN   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_STAGES = 2'd1;
   localparam logic signed [COEF_W-1:0] GAIN_RESET   = 32'sd268435456;
   localparam logic [ACT_W-1:0]         ACTIVE_RESET = 3'd4;

   typedef struct packed {
      logic                       command;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic [CIDX_W-1:0]          coef_index;
      logic signed [COEF_W-1:0]   coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       saturated;
   } rsp_type;

   // Coefficient slots within one stage and delay slots within one stage.
   typedef logic [2:0] slot_type;
   localparam slot_type SLOT_A1 = 3'd0;
   localparam slot_type SLOT_A2 = 3'd1;
   localparam slot_type SLOT_B0 = 3'd2;
   localparam slot_type SLOT_B1 = 3'd3;
   localparam slot_type SLOT_B2 = 3'd4;
   localparam logic DLY_Z1 = 1'b0;
   localparam logic DLY_Z2 = 1'b1;

   typedef enum logic [1:0] {Z_NONE, Z_LOAD1, Z_LOAD2} zld_type;
   typedef enum logic {MA_COEF, MA_GAIN} mula_type;
   typedef enum logic [1:0] {MB_Z1, MB_Z2, MB_W, MB_X} mulb_type;
   typedef enum logic [2:0] {ACC_HOLD, ACC_INIT, ACC_SUB, ACC_ADD, ACC_LOAD} acc_type;
   typedef enum logic [1:0] {DW_NONE, DW_Z2, DW_Z1} dwr_type;
   typedef enum logic [1:0] {SEQ_NEXT, SEQ_LOOP, SEQ_DONE} seq_type;

   typedef struct packed {
      logic     dly_rd;
      logic     dly_slot;
      logic     coef_rd;
      slot_type coef_slot;
      zld_type  zld;
      logic     mul_en;
      mula_type mula;
      mulb_type mulb;
      acc_type  acc;
      logic     wr_w;
      logic     wr_x;
      dwr_type  dwr;
      seq_type  seq;
   } ctrl_word_type;

   localparam ctrl_word_type UC_NOP = '{
      dly_rd: 1'b0, dly_slot: DLY_Z1, coef_rd: 1'b0, coef_slot: SLOT_A1,
      zld: Z_NONE, mul_en: 1'b0, mula: MA_COEF, mulb: MB_Z1, acc: ACC_HOLD,
      wr_w: 1'b0, wr_x: 1'b0, dwr: DW_NONE, seq: SEQ_NEXT};

   // Program counter and named program locations.
   typedef logic [3:0] pc_type;
   localparam pc_type PC_LOOP = 4'd0;
   localparam pc_type PC_RD_Z2 = 4'd1;
   localparam pc_type PC_MUL_A1 = 4'd2;
   localparam pc_type PC_MUL_A2 = 4'd3;
   localparam pc_type PC_MUL_B1 = 4'd4;
   localparam pc_type PC_ROUND_W = 4'd5;
   localparam pc_type PC_MUL_B0 = 4'd6;
   localparam pc_type PC_ACC_B0 = 4'd7;
   localparam pc_type PC_ROUND_X = 4'd8;
   localparam pc_type PC_GAIN = 4'd9;
   localparam pc_type PC_DONE = 4'd10;

   // Microcode program. Steps PC_LOOP..PC_ROUND_X run once per stage; memory
   // read data and products are each registered and used by the step that follows.
   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type cw;
      cw = UC_NOP;
      unique case (pc)
         PC_LOOP: begin
            cw.dly_rd = 1'b1; cw.dly_slot = DLY_Z1;
         end
         PC_RD_Z2: begin
            cw.dly_rd = 1'b1; cw.dly_slot = DLY_Z2;
            cw.zld = Z_LOAD1;
            cw.coef_rd = 1'b1; cw.coef_slot = SLOT_A1;
            cw.acc = ACC_INIT;
         end
         PC_MUL_A1: begin
            cw.zld = Z_LOAD2;
            cw.coef_rd = 1'b1; cw.coef_slot = SLOT_A2;
            cw.mul_en = 1'b1; cw.mula = MA_COEF; cw.mulb = MB_Z1;
         end
         PC_MUL_A2: begin
            cw.coef_rd = 1'b1; cw.coef_slot = SLOT_B1;
            cw.mul_en = 1'b1; cw.mula = MA_COEF; cw.mulb = MB_Z2;
            cw.acc = ACC_SUB;
         end
         PC_MUL_B1: begin
            cw.coef_rd = 1'b1; cw.coef_slot = SLOT_B2;
            cw.mul_en = 1'b1; cw.mula = MA_COEF; cw.mulb = MB_Z1;
            cw.acc = ACC_SUB;
         end
         PC_ROUND_W: begin
            cw.coef_rd = 1'b1; cw.coef_slot = SLOT_B0;
            cw.mul_en = 1'b1; cw.mula = MA_COEF; cw.mulb = MB_Z2;
            cw.wr_w = 1'b1; cw.acc = ACC_LOAD;
            cw.dwr = DW_Z2;
         end
         PC_MUL_B0: begin
            cw.mul_en = 1'b1; cw.mula = MA_COEF; cw.mulb = MB_W;
            cw.acc = ACC_ADD;
            cw.dwr = DW_Z1;
         end
         PC_ACC_B0: begin
            cw.acc = ACC_ADD;
         end
         PC_ROUND_X: begin
            cw.wr_x = 1'b1; cw.seq = SEQ_LOOP;
         end
         PC_GAIN: begin
            cw.mul_en = 1'b1; cw.mula = MA_GAIN; cw.mulb = MB_X;
         end
         PC_DONE: begin
            cw.seq = SEQ_DONE;
         end
         default: begin
            cw = UC_NOP;
         end
      endcase
      return cw;
   endfunction

   typedef struct packed {
      logic                    clip;
      logic signed [DLY_W-1:0] value;
   } rnd_dly_type;

   typedef struct packed {
      logic                       clip;
      logic signed [SAMPLE_W-1:0] value;
   } rnd_out_type;

   // Q14.50 sum to Q8.24: round half up, saturate to 32 bits.
   function automatic rnd_dly_type rnd_q824(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] sum;
      rnd_dly_type r;
      sum = acc + 64'sd33554432;
      r.clip = !((&sum[63:57]) || (~|sum[63:57]));
      if (r.clip) begin
         r.value = sum[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r.value = sum[57:26];
      end
      return r;
   endfunction

   // Q12.52 product to Q1.23: round half up, saturate to 24 bits.
   function automatic rnd_out_type rnd_q123(input logic signed [ACC_W-1:0] p);
      logic signed [ACC_W-1:0] sum;
      rnd_out_type r;
      sum = p + 64'sd268435456;
      r.clip = !((&sum[63:52]) || (~|sum[63:52]));
      if (r.clip) begin
         r.value = sum[63] ? 24'sh80_0000 : 24'sh7F_FFFF;
      end else begin
         r.value = sum[52:29];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/bqc_datapath.sv
// ----------------------------------------------------------------------------
// Biquad cascade datapath
// Shared multiplier, accumulator, rounding unit and working registers,
// driven one control word per cycle by the sequencer.
// ----------------------------------------------------------------------------
module bqc_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [bqc_pkg::SAMPLE_W-1:0]     sample,
   input  bqc_pkg::ctrl_word_type                  cw,
   input  logic signed [bqc_pkg::COEF_W-1:0]       coef_q,
   input  logic signed [bqc_pkg::DLY_W-1:0]        dly_q,
   input  logic signed [bqc_pkg::COEF_W-1:0]       gain,
   output logic signed [bqc_pkg::DLY_W-1:0]        z1,
   output logic signed [bqc_pkg::DLY_W-1:0]        w,
   output logic signed [bqc_pkg::SAMPLE_W-1:0]     out_sample,
   output logic                                    out_clip,
   output logic                                    flag
);
   import bqc_pkg::*;

   logic signed [DLY_W-1:0] x_ff, x_in;
   logic signed [DLY_W-1:0] z1_ff, z1_in;
   logic signed [DLY_W-1:0] z2_ff, z2_in;
   logic signed [DLY_W-1:0] w_ff, w_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    flag_ff, flag_in;

   logic signed [COEF_W-1:0] mul_a;
   logic signed [DLY_W-1:0]  mul_b;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  acc_init;
   rnd_dly_type              rnd_acc;
   rnd_out_type              rnd_out;

   // Operand selection, product scaling and rounding.
   always_comb begin
      mul_a = (cw.mula == MA_GAIN) ? gain : coef_q;
      unique case (cw.mulb)
         MB_Z1:   mul_b = z1_ff;
         MB_Z2:   mul_b = z2_ff;
         MB_W:    mul_b = w_ff;
         MB_X:    mul_b = x_ff;
         default: mul_b = x_ff;
      endcase
      term     = prod_ff >>> 2;
      acc_init = {{(ACC_W-DLY_W-ACC_FRAC_SH){x_ff[DLY_W-1]}}, x_ff, {ACC_FRAC_SH{1'b0}}};
      rnd_acc  = rnd_q824(acc_ff);
      rnd_out  = rnd_q123(prod_ff);
   end

   // Next values of the working registers.
   always_comb begin
      x_in    = x_ff;
      z1_in   = z1_ff;
      z2_in   = z2_ff;
      w_in    = w_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      flag_in = flag_ff;
      if (start) begin
         x_in    = {{(DLY_W-SAMPLE_W-1){sample[SAMPLE_W-1]}}, sample, 1'b0};
         flag_in = 1'b0;
      end else begin
         if (cw.wr_x) begin
            x_in = rnd_acc.value;
         end
         if ((cw.wr_x || cw.wr_w) && rnd_acc.clip) begin
            flag_in = 1'b1;
         end
      end
      if (cw.wr_w) begin
         w_in = rnd_acc.value;
      end
      unique case (cw.zld)
         Z_LOAD1: z1_in = dly_q;
         Z_LOAD2: z2_in = dly_q;
         default: ;
      endcase
      if (cw.mul_en) begin
         prod_in = ACC_W'(mul_a) * ACC_W'(mul_b);
      end
      unique case (cw.acc)
         ACC_INIT: acc_in = acc_init;
         ACC_SUB:  acc_in = acc_ff - term;
         ACC_ADD:  acc_in = acc_ff + term;
         ACC_LOAD: acc_in = term;
         default:  acc_in = acc_ff;
      endcase
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      z1_ff   <= z1_in;
      z2_ff   <= z2_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Saturation flag for the sample in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   assign z1         = z1_ff;
   assign w          = w_ff;
   assign out_sample = rnd_out.value;
   assign out_clip   = rnd_out.clip;
   assign flag       = flag_ff;

endmodule

>>> hw/rtl/biquad_cascade_highpass_top.sv
// ----------------------------------------------------------------------------
// Biquad cascade high-pass filter top level
// Microcoded cascade of direct-form-II biquad sections with output gain.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one item per transfer. Command CMD_COEF stores
// coef_value at coef_index (stage*5 + slot a1,a2,b0,b1,b2) and
// returns nothing; indexes past the last stage are dropped. Command
// CMD_FILTER runs sample_in through the first active_stages sections and the
// output gain, then returns one rsp item with the rounded, saturated sample
// and a flag that is set when any intermediate or the output was clipped.
// A filter item runs the microcode loop once per active stage, then the
// gain multiply and output rounding. The single shared multiplier serves
// all steps, so a new item is taken only after the previous result has
// been loaded into the output register.
// req_stall is high while a sample is in work. When rsp_stall holds the
// result, the sequencer waits on its last step; the output register keeps
// the pending transfer. The csr port is always ready; write it only while
// idle. Reset clears coefficients, delay values and state, and loads the
// gain with 1.0 and active_stages with 4; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "biquad_cascade_highpass_top_defines.svh"

module biquad_cascade_highpass_top #(
   parameter int STAGES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bqc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bqc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bqc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_wdata
);
   import bqc_pkg::*;

   localparam int COEF_DEPTH = COEF_PER_STAGE * STAGES;
   localparam int DLY_DEPTH  = DLY_PER_STAGE * STAGES;
   localparam int CADDR_W    = $clog2(COEF_DEPTH);
   localparam int DADDR_W    = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
   localparam int SIDX_W     = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int IDX_W      = (CADDR_W > CIDX_W) ? CADDR_W : CIDX_W;

   // Configuration registers.
   logic signed [COEF_W-1:0] gain_ff, gain_in;
   logic [ACT_W-1:0]         act_ff, act_in;

   // Sequencer state.
   logic               busy_ff, busy_in;
   pc_type             pc_ff, pc_in;
   logic [SIDX_W-1:0]  stage_ff, stage_in;
   logic [SIDX_W-1:0]  last_ff, last_in;
   logic [CADDR_W-1:0] cbase_ff, cbase_in;
   logic [DADDR_W-1:0] dbase_ff, dbase_in;

   // Memories and their registered read data.
   logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
   logic [COEF_DEPTH-1:0]    coef_vld_ff;
   logic signed [COEF_W-1:0] coef_q_ff;
   logic signed [DLY_W-1:0]  dly_mem [DLY_DEPTH];
   logic [DLY_DEPTH-1:0]     dly_vld_ff;
   logic signed [DLY_W-1:0]  dly_q_ff;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   ctrl_word_type            cw;
   logic                     sample_go;
   logic                     coef_go;
   logic                     out_load;
   logic                     last_stage;
   logic [IDX_W-1:0]         cidx_ext;
   logic                     cidx_ok;
   logic [CADDR_W-1:0]       cwr_addr;
   logic [CADDR_W-1:0]       crd_addr;
   logic [DADDR_W-1:0]       drd_addr;
   logic [DADDR_W-1:0]       dwr_addr;
   logic signed [DLY_W-1:0]  dwr_data;
   logic signed [DLY_W-1:0]  dp_z1;
   logic signed [DLY_W-1:0]  dp_w;
   logic signed [SAMPLE_W-1:0] dp_out;
   logic                     dp_clip;
   logic                     dp_flag;

   // Transfers on the request channel and the control word of this step.
   always_comb begin
      sample_go  = req_valid && !busy_ff && (req_data.command == CMD_FILTER);
      coef_go    = req_valid && !busy_ff && (req_data.command == CMD_COEF);
      cw         = busy_ff ? ucode_rom(pc_ff) : UC_NOP;
      out_load   = busy_ff && (cw.seq == SEQ_DONE) && (!rsp_valid_ff || !rsp_stall);
      last_stage = (stage_ff == last_ff);
      cidx_ext   = IDX_W'(req_data.coef_index);
      cidx_ok    = (cidx_ext < IDX_W'(COEF_DEPTH));
      cwr_addr   = cidx_ext[CADDR_W-1:0];
      crd_addr   = cbase_ff + CADDR_W'(cw.coef_slot);
      drd_addr   = dbase_ff + DADDR_W'(cw.dly_slot);
      dwr_addr   = (cw.dwr == DW_Z2) ? (dbase_ff + DADDR_W'(DLY_Z2)) : dbase_ff;
      dwr_data   = (cw.dwr == DW_Z2) ? dp_z1 : dp_w;
   end

   // Last stage index: zero stages act as one, too many act as STAGES.
   always_comb begin
      if (act_ff == '0) begin
         last_in = '0;
      end else if (int'(act_ff) > STAGES) begin
         last_in = SIDX_W'(STAGES - 1);
      end else begin
         last_in = SIDX_W'(act_ff - 3'd1);
      end
   end

   // Sequencer next state.
   always_comb begin
      busy_in  = busy_ff;
      pc_in    = pc_ff;
      stage_in = stage_ff;
      cbase_in = cbase_ff;
      dbase_in = dbase_ff;
      if (sample_go) begin
         busy_in  = 1'b1;
         pc_in    = PC_LOOP;
         stage_in = '0;
         cbase_in = '0;
         dbase_in = '0;
      end else if (busy_ff) begin
         unique case (cw.seq)
            SEQ_NEXT: begin
               pc_in = pc_ff + 4'd1;
            end
            SEQ_LOOP: begin
               if (last_stage) begin
                  pc_in = PC_GAIN;
               end else begin
                  pc_in    = PC_LOOP;
                  stage_in = stage_ff + SIDX_W'(1);
                  cbase_in = cbase_ff + CADDR_W'(COEF_PER_STAGE);
                  dbase_in = dbase_ff + DADDR_W'(DLY_PER_STAGE);
               end
            end
            SEQ_DONE: begin
               if (out_load) begin
                  busy_in = 1'b0;
                  pc_in   = PC_LOOP;
               end
            end
            default: begin
               pc_in = pc_ff;
            end
         endcase
      end
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pc_ff    <= PC_LOOP;
         stage_ff <= '0;
         last_ff  <= '0;
         cbase_ff <= '0;
         dbase_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         pc_ff    <= pc_in;
         stage_ff <= stage_in;
         cbase_ff <= cbase_in;
         dbase_ff <= dbase_in;
         if (sample_go) begin
            last_ff <= last_in;
         end
      end
   end

   // Configuration register writes.
   always_comb begin
      gain_in = gain_ff;
      act_in  = act_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_OUTPUT_GAIN) begin
            gain_in = csr_wdata;
         end else if (csr_index == CSR_ACTIVE_STAGES) begin
            act_in = csr_wdata[ACT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         act_ff  <= ACTIVE_RESET;
      end else begin
         gain_ff <= gain_in;
         act_ff  <= act_in;
      end
   end

   // Coefficient memory: written by coefficient transfers, read by microcode.
   always_ff @(posedge clock) begin
      if (coef_go && cidx_ok) begin
         coef_mem[cwr_addr] <= req_data.coef_value;
      end
      if (cw.coef_rd) begin
         coef_q_ff <= coef_vld_ff[crd_addr] ? coef_mem[crd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (coef_go && cidx_ok) begin
         coef_vld_ff[cwr_addr] <= 1'b1;
      end
   end

   // Delay value memory: z1 of stage s at 2s, z2 at 2s+1.
   always_ff @(posedge clock) begin
      if (cw.dwr != DW_NONE) begin
         dly_mem[dwr_addr] <= dwr_data;
      end
      if (cw.dly_rd) begin
         dly_q_ff <= dly_vld_ff[drd_addr] ? dly_mem[drd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_vld_ff <= '0;
      end else if (cw.dwr != DW_NONE) begin
         dly_vld_ff[dwr_addr] <= 1'b1;
      end
   end

   // Shared arithmetic.
   bqc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .start      (sample_go),
      .sample     (req_data.sample_in),
      .cw         (cw),
      .coef_q     (coef_q_ff),
      .dly_q      (dly_q_ff),
      .gain       (gain_ff),
      .z1         (dp_z1),
      .w          (dp_w),
      .out_sample (dp_out),
      .out_clip   (dp_clip),
      .flag       (dp_flag)
   );

   // Output register holds the result until its transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.sample_out <= dp_out;
         rsp_data_ff.saturated  <= dp_flag || dp_clip;
      end
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Sequencer checks.
   `BQC_ASSERT_NEXT(a_start_busy, clock, reset, sample_go, busy_ff && (pc_ff == PC_LOOP))
   `BQC_ASSERT_SAME(a_idle_pc, clock, reset, !busy_ff, pc_ff == PC_LOOP)
   `BQC_ASSERT_SAME(a_stage_bound, clock, reset, busy_ff, stage_ff <= last_ff)
   `BQC_ASSERT_SAME(a_load_at_done, clock, reset, out_load, busy_ff && (pc_ff == PC_DONE))

endmodule
